/* rtl/core/tdefsm_pkg.sv */
`timescale 1ns / 1ps
package tdefsm_pkg;

    localparam int NUM_STATES     = 5;
    localparam int MAX_CONDITIONS = 3;
    localparam int STATE_W        = 3;
    localparam int IDX_W          = 2;
    localparam int CNT_W          = 2;
    localparam int ROW_W          = CNT_W + MAX_CONDITIONS * STATE_W;
    localparam int JUMP_W         = 4;
    localparam int CFG_IDX_W      = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STATE0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_MODE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START      = 3'd6;

    // Item kinds carried in tuser
    localparam logic FUNC_POST = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    localparam logic [STATE_W-1:0] START_RESET = 3'd0;
    localparam logic               CHAIN_RESET = 1'b1;

    typedef logic [ROW_W-1:0]   row_t;
    typedef logic [STATE_W-1:0] state_id_t;
    typedef logic [MAX_CONDITIONS-1:0] flags_t;

    localparam row_t ROW_RESET [NUM_STATES] = '{
        11'd50, 11'd78, 11'd1, 11'd17, 11'd9
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } seq_state_t;

    // Outcome of one scan of a state's conditions
    typedef struct packed {
        logic                     found;
        logic [IDX_W-1:0]         idx;
        state_id_t                nxt;
    } scan_res_t;

    // Map an out-of-range state number to state 0
    function automatic state_id_t valid_state(input state_id_t v);
        valid_state = (32'(v) < NUM_STATES) ? v : '0;
    endfunction

endpackage

/* rtl/core/tdefsm_scan.sv */
`timescale 1ns / 1ps
module tdefsm_scan import tdefsm_pkg::*; (
    input  row_t      row,
    input  flags_t    flags,
    output scan_res_t res
);

    logic [CNT_W-1:0] cnt_eff;

    // Clamp the condition count to the number of conditions held
    always_comb begin
        if (32'(row[CNT_W-1:0]) > MAX_CONDITIONS) begin
            cnt_eff = CNT_W'(MAX_CONDITIONS);
        end else begin
            cnt_eff = row[CNT_W-1:0];
        end
    end

    // Pick the highest-priority set flag within the count
    always_comb begin
        res = '0;
        for (int j = 0; j < MAX_CONDITIONS; j++) begin
            if (!res.found && (j < 32'(cnt_eff)) && flags[j]) begin
                res.found = 1'b1;
                res.idx   = IDX_W'(j);
                res.nxt   = row[CNT_W + j*STATE_W +: STATE_W];
            end
        end
    end

endmodule

/* rtl/core/tdefsm_seq.sv */
`timescale 1ns / 1ps
module tdefsm_seq import tdefsm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  row_t              rows [NUM_STATES],
    input  logic              chain_mode,
    input  logic              load_start,
    input  state_id_t         load_value,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_func,
    input  state_id_t         in_state,
    input  logic [IDX_W-1:0]  in_index,
    input  logic              out_free,
    output logic              res_valid,
    output state_id_t         res_state,
    output logic [JUMP_W-1:0] res_jumps
);

    seq_state_t        state_reg, state_next;
    state_id_t         present_reg, present_next;
    flags_t            flags_reg [NUM_STATES];
    flags_t            flags_next [NUM_STATES];
    logic [JUMP_W-1:0] jumps_reg, jumps_next;
    scan_res_t         scan;

    tdefsm_scan u_scan (
        .row   (rows[present_reg]),
        .flags (flags_reg[present_reg]),
        .res   (scan)
    );

    // Hold sequencer state, present state and latched flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            present_reg <= valid_state(START_RESET);
            jumps_reg   <= '0;
            for (int i = 0; i < NUM_STATES; i++) begin
                flags_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            present_reg <= present_next;
            jumps_reg   <= jumps_next;
            flags_reg   <= flags_next;
        end
    end

    // Post flags, step the scan one state per cycle, hand over the result
    always_comb begin
        state_next   = state_reg;
        present_next = present_reg;
        jumps_next   = jumps_reg;
        flags_next   = flags_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        res_state    = present_reg;
        res_jumps    = jumps_reg;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_func == FUNC_RUN) begin
                        jumps_next = '0;
                        state_next = ST_RUN;
                    end else if ((32'(in_state) < NUM_STATES) &&
                                 (32'(in_index) < MAX_CONDITIONS)) begin
                        flags_next[in_state][in_index] = 1'b1;
                    end
                end
                if (load_start) begin
                    present_next = valid_state(load_value);
                end
            end
            ST_RUN: begin
                if (scan.found) begin
                    flags_next[present_reg][scan.idx] = 1'b0;
                    if (32'(scan.nxt) < NUM_STATES) begin
                        present_next = scan.nxt;
                    end
                    if (jumps_reg != '1) begin
                        jumps_next = jumps_reg + 1'b1;
                    end
                end
                if (!scan.found || !chain_mode) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/table_driven_event_fsm.sv */
`timescale 1ns / 1ps
// Programmable event-driven state machine.
// Input channel (s_): each transfer is a post (tuser = 0) that latches one
// condition flag of a state, or a run (tuser = 1) that scans the present
// state's conditions in priority order and jumps on the first set flag,
// clearing it; in chain mode it repeats from the new state.
// Result channel (m_): one transfer per run item carrying the final state
// and the number of jumps taken (saturating at 15). Posts give no result.
// Configuration: cfg_we/cfg_index/cfg_wdata write the five transition rows,
// chain mode and start state; writing the start state also loads the
// present state. Write only while the block is idle.
// Timing: posts can follow back to back. A run scans one state per cycle
// in the shared scan unit; in chain mode it repeats until a scan finds no
// flag, in single mode it stops after the first scan, then its result is
// handed over into the registered m_ output. s_tready is low from the
// run's transfer until the hand-over, so no transfer is accepted meanwhile.
// Reset: rows, chain mode and start state return to defaults, all flags
// clear and the present state is state 0.
// Back-pressure: a finished result waits in the output register; a run
// whose result finds the register full waits until m_tready frees it, and
// s_tready stays low meanwhile, so no post or run is accepted.
module table_driven_event_fsm import tdefsm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [2:0] event_state, [4:3] event_index
    input  logic                 s_tuser,   // [0] func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [2:0] current_state, [6:3] jumps_taken
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ROW_W-1:0]     cfg_wdata
);

    row_t              rows_reg [NUM_STATES];
    logic              chain_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    state_id_t         out_state_reg;
    logic [JUMP_W-1:0] out_jumps_reg;
    logic              load_start;
    logic              out_free;
    logic              res_valid;
    state_id_t         res_state;
    logic [JUMP_W-1:0] res_jumps;

    assign load_start = cfg_we && (cfg_index == CFG_START);
    assign out_free   = !m_tvalid_reg || m_tready;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= ROW_RESET;
            chain_reg <= CHAIN_RESET;
        end else if (cfg_we) begin
            if (32'(cfg_index) < 32'(CFG_ROW_STATE0) + NUM_STATES) begin
                rows_reg[cfg_index] <= cfg_wdata;
            end else if (cfg_index == CFG_CHAIN_MODE) begin
                chain_reg <= cfg_wdata[0];
            end
        end
    end

    tdefsm_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rows       (rows_reg),
        .chain_mode (chain_reg),
        .load_start (load_start),
        .load_value (cfg_wdata[STATE_W-1:0]),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tuser),
        .in_state   (s_tdata[STATE_W-1:0]),
        .in_index   (s_tdata[STATE_W +: IDX_W]),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res_state  (res_state),
        .res_jumps  (res_jumps)
    );

    // Output register: load on a finished run, drop once transferred
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_state_reg <= res_state;
            out_jumps_reg <= res_jumps;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_jumps_reg, out_state_reg};

endmodule

/* sim/tb_table_driven_event_fsm.sv */
`timescale 1ns / 1ps
module tb_table_driven_event_fsm;
    import tdefsm_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    // Margin after the longest run before touching config
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 600;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Index past the last register: the block must ignore it
    localparam cfg_idx_t CFG_SPARE = 3'd7;

    typedef enum { ROWS_RANDOM, ROWS_ZERO, ROWS_FULL, ROWS_LADDER } row_plan_t;
    typedef enum { RX_OPEN, RX_COIN, RX_SPARSE } rx_mode_t;

    typedef struct packed {
        state_id_t         st;
        logic [JUMP_W-1:0] jumps;
    } run_result_t;

    // Shadow of the machine: rows, mode, present state and latched flags
    class fsm_scoreboard;
        row_t        rows [NUM_STATES];
        logic        chain;
        state_id_t   present;
        flags_t      flags [NUM_STATES];
        run_result_t runs_due [$];
        int          errors;

        function void reset_state();
            for (int i = 0; i < NUM_STATES; i++) begin
                rows[i]  = ROW_RESET[i];
                flags[i] = '0;
            end
            chain   = CHAIN_RESET;
            present = START_RESET;
            runs_due.delete();
            errors  = 0;
        endfunction

        function void write_reg(input cfg_idx_t idx, input row_t data);
            if (int'(idx) < int'(CFG_ROW_STATE0) + NUM_STATES) begin
                rows[int'(idx) - int'(CFG_ROW_STATE0)] = data;
            end else if (idx == CFG_CHAIN_MODE) begin
                chain = data[0];
            end else if (idx == CFG_START) begin
                // out-of-range start loads state 0
                present = (int'(data[STATE_W-1:0]) < NUM_STATES) ?
                          data[STATE_W-1:0] : '0;
            end
        endfunction

        // Apply one accepted transfer; a run queues its result
        function void note_item(input logic func, input state_id_t est,
                                input logic [IDX_W-1:0] eidx);
            state_id_t   s;
            state_id_t   nxt;
            row_t        row;
            int          cnt;
            int          jumps;
            logic        found;
            run_result_t res;
            if (func == FUNC_POST) begin
                if (int'(est) < NUM_STATES && int'(eidx) < MAX_CONDITIONS)
                    flags[est][eidx] = 1'b1;
                return;
            end
            s     = present;
            jumps = 0;
            for (int it = 0; it < NUM_STATES * MAX_CONDITIONS; it++) begin
                row = rows[s];
                cnt = int'(row[CNT_W-1:0]);
                if (cnt > MAX_CONDITIONS)
                    cnt = MAX_CONDITIONS;
                found = 1'b0;
                // first set flag in priority order wins
                for (int j = 0; j < cnt && !found; j++) begin
                    if (flags[s][j]) begin
                        nxt         = row[CNT_W + STATE_W * j +: STATE_W];
                        flags[s][j] = 1'b0;
                        if (int'(nxt) < NUM_STATES)
                            s = nxt;
                        jumps++;
                        found = 1'b1;
                    end
                end
                if (!found || !chain)
                    break;
            end
            present   = s;
            res.st    = s;
            res.jumps = (jumps > 15) ? 4'd15 : JUMP_W'(jumps);
            runs_due.push_back(res);
        endfunction

        function void check_result(input logic [7:0] data);
            run_result_t want;
            if (runs_due.size() == 0) begin
                $error("result transfer with no run outstanding: tdata %h", data);
                errors++;
                return;
            end
            want = runs_due.pop_front();
            if (data[2:0] !== want.st) begin
                $error("current_state: expected %0d, got %0d", want.st, data[2:0]);
                errors++;
            end
            if (data[6:3] !== want.jumps) begin
                $error("jumps_taken: expected %0d, got %0d", want.jumps, data[6:3]);
                errors++;
            end
        endfunction

        function int pending();
            return runs_due.size();
        endfunction
    endclass

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = '0;
    logic             s_tuser   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [7:0]       m_tdata;
    logic             cfg_we    = 1'b0;
    cfg_idx_t         cfg_index = '0;
    row_t             cfg_wdata = '0;

    fsm_scoreboard    sb;
    int               burst_left = 0;
    int               cycles     = 0;
    logic             hold_req   = 1'b0;

    table_driven_event_fsm u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb_table_driven_event_fsm NOT OK");
            $finish;
        end
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Receiver: random stall pattern, plus one long hold-off on request
    initial begin : receiver
        int       phase_left;
        int       hold_left;
        rx_mode_t mode;
        phase_left = 0;
        hold_left  = 0;
        mode       = RX_OPEN;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                if (phase_left == 0) begin
                    mode       = rx_mode_t'($urandom_range(0, 2));
                    phase_left = $urandom_range(5, 60);
                end
                phase_left--;
                case (mode)
                    RX_OPEN: m_tready = 1'b1;
                    RX_COIN: m_tready = ($urandom_range(0, 1) == 1);
                    default: m_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Insert a gap once the current burst is used up
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 24);
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
        @(negedge aclk);
        s_tvalid = 1'b0;
        repeat (gap - 1) @(negedge aclk);
    endtask

    task automatic send_item(input logic func, input state_id_t est,
                             input logic [IDX_W-1:0] eidx);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = func;
        s_tdata  = {3'b000, eidx, est};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(func, est, eidx);
        pace();
    endtask

    // Hold the input until every run result is back, then let posts settle
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input row_t data);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(posedge aclk);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic configure(input row_plan_t plan, input row_t chain_word,
                             input row_t start_word);
        row_t      r;
        state_id_t hop;
        drain();
        for (int i = 0; i < NUM_STATES; i++) begin
            // ladder: conditions 0 and 1 jump out of range (stay put),
            // condition 2 steps to the next state; the last state stays
            hop = (i == NUM_STATES - 1) ? 3'd7 : state_id_t'(i + 1);
            case (plan)
                ROWS_ZERO:   r = '0;
                ROWS_FULL:   r = '1;
                ROWS_LADDER: r = {hop, 3'd7, 3'd7, 2'd3};
                default:     r = row_t'($urandom);
            endcase
            cfg_write(cfg_idx_t'(int'(CFG_ROW_STATE0) + i), r);
        end
        cfg_write(CFG_CHAIN_MODE, chain_word);
        cfg_write(CFG_START, start_word);
    endtask

    // Mostly posts followed by a run, with some raw noise mixed in
    task automatic random_items(input int n);
        int        sent;
        int        posts;
        state_id_t st;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) < 8) begin
                posts = $urandom_range(0, 5);
                repeat (posts) begin
                    st = ($urandom_range(0, 1) == 0) ? sb.present :
                         state_id_t'($urandom_range(0, NUM_STATES - 1));
                    send_item(FUNC_POST, st, IDX_W'($urandom_range(0, MAX_CONDITIONS - 1)));
                end
                send_item(FUNC_RUN, 3'($urandom), 2'($urandom));
                sent += posts + 1;
            end else begin
                send_item(1'($urandom), 3'($urandom), 2'($urandom));
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        sb = new();
        sb.reset_state();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Defaults: run with nothing pending, ignored posts, a flag beyond
        // the state's count, a single jump and a four-step chain
        send_item(FUNC_RUN,  3'd0, 2'd0);
        send_item(FUNC_POST, 3'd5, 2'd0);
        send_item(FUNC_POST, 3'd7, 2'd2);
        send_item(FUNC_POST, 3'd0, 2'd3);
        send_item(FUNC_RUN,  3'd7, 2'd3);
        send_item(FUNC_POST, 3'd2, 2'd2);
        send_item(FUNC_POST, 3'd0, 2'd1);
        send_item(FUNC_RUN,  3'd0, 2'd0);
        send_item(FUNC_POST, 3'd1, 2'd0);
        send_item(FUNC_POST, 3'd1, 2'd1);
        send_item(FUNC_POST, 3'd3, 2'd0);
        send_item(FUNC_POST, 3'd4, 2'd0);
        send_item(FUNC_POST, 3'd2, 2'd0);
        send_item(FUNC_RUN,  3'd0, 2'd0);
        send_item(FUNC_RUN,  3'd0, 2'd0);
        random_items(250);

        // Long receiver hold-off while the sender keeps pushing
        hold_req = 1'b1;
        random_items(200);

        // Zero condition counts everywhere
        configure(ROWS_ZERO, 11'd1, 11'd4);
        random_items(80);

        // All-ones rows, single mode, start beyond range; spare index ignored
        configure(ROWS_FULL, 11'd0, 11'd7);
        cfg_write(CFG_SPARE, row_t'($urandom));
        random_items(150);

        // Ladder: all fifteen flags give the longest chain
        configure(ROWS_LADDER, 11'd1, 11'd0);
        for (int s = 0; s < NUM_STATES; s++)
            for (int j = 0; j < MAX_CONDITIONS; j++)
                send_item(FUNC_POST, state_id_t'(s), IDX_W'(j));
        send_item(FUNC_RUN, 3'd0, 2'd0);
        random_items(150);

        configure(ROWS_LADDER, 11'd0, 11'd2);
        random_items(100);

        // Random tables with full-width mode and start words
        for (int k = 0; k < 4; k++) begin
            configure(ROWS_RANDOM, row_t'($urandom) ^ 11'(k & 1), row_t'($urandom));
            random_items(250);
        end

        drain();
        if (sb.errors == 0) begin
            $display("tb_table_driven_event_fsm OK");
        end else begin
            $display("tb_table_driven_event_fsm NOT OK");
        end
        $finish;
    end

endmodule
